// File: rtl/shgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package shgc_pkg;

   localparam int ID_W     = 6;
   localparam int ENERGY_W = 16;
   localparam int TIMING_W = 16;
   localparam int DET_W    = 4;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 3;
   localparam int GRADE_W  = 3;
   localparam int TDIFF_W  = TIMING_W + 1;

   // Bit positions in the per-hit error flags.
   localparam int ERR_ZERO_ENERGY = 0;
   localparam int ERR_MULTI_HIT   = 1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK             = 3'd0,
      STATUS_ZERO_ENERGY    = 3'd1,
      STATUS_MULTI_HIT      = 3'd2,
      STATUS_SIDE_EMPTY     = 3'd3,
      STATUS_NON_ADJACENT   = 3'd4,
      STATUS_TIMING_MISSING = 3'd5
   } status_type;

   typedef enum logic {
      SIDE_LV = 1'b0,
      SIDE_HV = 1'b1
   } side_type;

   typedef struct packed {
      side_type              side;
      logic [ID_W-1:0]       strip_id;
      logic [ENERGY_W-1:0]   strip_energy;
      logic [TIMING_W-1:0]   strip_timing;
      logic [DET_W-1:0]      detector_id;
      logic                  last_strip;
   } item_type;

   typedef struct packed {
      logic [COUNT_W-1:0]    count;
      logic [ID_W-1:0]       min_id;
      logic [ID_W-1:0]       max_id;
      logic [ENERGY_W-1:0]   energy;
      logic [TIMING_W-1:0]   timing;
      logic [ID_W-1:0]       id;
      logic [DET_W-1:0]      det;
   } side_acc_type;

   typedef struct packed {
      side_acc_type          lv;
      side_acc_type          hv;
      logic [1:0]            err;
   } hit_acc_type;

   // First member sits in the highest bits, so status ends up at bit 0.
   typedef struct packed {
      logic [TDIFF_W-1:0]    timing_difference;
      logic [DET_W-1:0]      hit_detector;
      logic [ID_W-1:0]       hv_dominant_id;
      logic [ID_W-1:0]       lv_dominant_id;
      logic [GRADE_W-1:0]    grade;
      status_type            status;
   } result_type;

   localparam side_acc_type SIDE_CLEAR = '{
      count:  '0,
      min_id: '1,
      max_id: '0,
      energy: '0,
      timing: '0,
      id:     '0,
      det:    '0
   };

   localparam hit_acc_type HIT_CLEAR = '{lv: SIDE_CLEAR, hv: SIDE_CLEAR, err: '0};

   // Sub-pixel grade from the low- and high-voltage strip counts.
   function automatic logic [GRADE_W-1:0] grade_of(input logic [COUNT_W-1:0] lv_n,
                                                   input logic [COUNT_W-1:0] hv_n);
      logic [GRADE_W-1:0] g;
      begin
         case ({lv_n, hv_n})
            {7'd1, 7'd1}, {7'd3, 7'd3}, {7'd1, 7'd3}, {7'd3, 7'd1}: g = 3'd0;
            {7'd1, 7'd2}, {7'd3, 7'd2}:                             g = 3'd1;
            {7'd2, 7'd1}, {7'd2, 7'd3}:                             g = 3'd2;
            {7'd2, 7'd2}:                                           g = 3'd3;
            default:                                                g = 3'd4;
         endcase
         return g;
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/strip_hit_grade_classifier_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake              Payload
// req_     in         req_tvalid/tready      strip hit; side in tuser, last strip in tlast
// rsp_     out        rsp_tvalid/tready      classification of one detector hit
// csr_     in         csr_valid/csr_ready    timing_min write data, always ready
//
// One strip hit is taken per cycle with no gaps, as long as the result side keeps up.
// rsp_tvalid rises once the strip flagged last has passed, in order, the input register,
// which takes the strip at the transfer, the snapshot of the finished hit and the result
// register. The per-hit accumulators sit in the second stage and take one update
// per cycle.
// Reset is synchronous and active high; it clears the accumulators, the seen-map and
// all valid flags and sets timing_min to 1. There is no clearing pass after reset.
// A stall on rsp_tready holds only the last-strip path: strips that are not last
// keep flowing into the accumulators while a result waits to be taken.

module strip_hit_grade_classifier_top
   import shgc_pkg::*;
#(
   parameter int STRIPS_PER_SIDE = 64,
   parameter int MAX_STRIP_HITS  = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   // strip_id [5:0], strip_energy [21:6], strip_timing [37:22], detector_id [41:38],
   // zero padding [47:42]
   input  wire logic [47:0] req_tdata,
   // side [0]
   input  wire logic        req_tuser,
   input  wire logic        req_tlast,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status [2:0], grade [5:3], lv_dominant_id [11:6], hv_dominant_id [17:12],
   // hit_detector [21:18], timing_difference [38:22], zero padding [39]
   output logic [39:0]      rsp_tdata,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_wdata
);

   localparam int IDX_W = $clog2(STRIPS_PER_SIDE);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_STRIP_HITS);

   // Configuration register.
   logic [TIMING_W-1:0] timing_min_ff, timing_min_in;

   // Stage 1: input register.
   logic                item_valid_ff, item_valid_in;
   item_type            item_ff, item_in;

   // Stage 2: accumulators, seen-map and snapshot of a finished hit.
   hit_acc_type         acc_ff, acc_in;
   logic [1:0][STRIPS_PER_SIDE-1:0] seen_ff, seen_in;
   logic                snap_valid_ff, snap_valid_in;
   hit_acc_type         snap_ff, snap_in;

   // Stage 3: result register.
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_data_ff, rsp_data_in;

   logic                req_fire;
   logic                out_free;
   logic                snap_move;
   logic                snap_free;
   logic                item_move;
   logic                item_free;

   logic                in_range;
   logic [IDX_W-1:0]    seen_idx;
   logic                seen_hit;
   side_acc_type        cur_side;
   side_acc_type        upd_side;
   hit_acc_type         acc_upd;

   logic [ID_W-1:0]     lv_span;
   logic [ID_W-1:0]     hv_span;

   // ------------------------------------------------------------------
   // Flow control. Strips that are not last never wait on the result side.
   // ------------------------------------------------------------------
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign snap_move  = snap_valid_ff && out_free;
   assign snap_free  = !snap_valid_ff || snap_move;
   assign item_move  = item_valid_ff && (!item_ff.last_strip || snap_free);
   assign item_free  = !item_valid_ff || item_move;
   assign req_tready = item_free;
   assign req_fire   = req_tvalid && req_tready;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   always_comb begin
      timing_min_in = timing_min_ff;
      if (csr_valid && csr_ready) begin
         timing_min_in = csr_wdata;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1
   // ------------------------------------------------------------------
   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      if (req_fire) begin
         item_valid_in        = 1'b1;
         item_in.side         = side_type'(req_tuser);
         item_in.strip_id     = req_tdata[5:0];
         item_in.strip_energy = req_tdata[21:6];
         item_in.strip_timing = req_tdata[37:22];
         item_in.detector_id  = req_tdata[41:38];
         item_in.last_strip   = req_tlast;
      end else if (item_move) begin
         item_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: fold the strip into its side, then clear on the last strip.
   // ------------------------------------------------------------------
   assign in_range = (32'(item_ff.strip_id) < 32'(STRIPS_PER_SIDE));
   assign seen_idx = IDX_W'(item_ff.strip_id);
   assign seen_hit = in_range && seen_ff[item_ff.side][seen_idx];
   assign cur_side = (item_ff.side == SIDE_LV) ? acc_ff.lv : acc_ff.hv;

   always_comb begin
      upd_side = cur_side;
      // The first strip of a side always takes the lead; on a tie the earlier one stays.
      if (cur_side.count == '0 || item_ff.strip_energy > cur_side.energy) begin
         upd_side.energy = item_ff.strip_energy;
         upd_side.timing = item_ff.strip_timing;
         upd_side.id     = item_ff.strip_id;
         upd_side.det    = (item_ff.side == SIDE_LV) ? item_ff.detector_id : '0;
      end
      if (item_ff.strip_id < cur_side.min_id) begin
         upd_side.min_id = item_ff.strip_id;
      end
      if (item_ff.strip_id > cur_side.max_id) begin
         upd_side.max_id = item_ff.strip_id;
      end
      if (cur_side.count < MAX_COUNT) begin
         upd_side.count = cur_side.count + 1'b1;
      end

      acc_upd = acc_ff;
      if (item_ff.side == SIDE_LV) begin
         acc_upd.lv = upd_side;
      end else begin
         acc_upd.hv = upd_side;
      end
      if (item_ff.strip_energy == '0) begin
         acc_upd.err[ERR_ZERO_ENERGY] = 1'b1;
      end
      if (seen_hit) begin
         acc_upd.err[ERR_MULTI_HIT] = 1'b1;
      end
   end

   always_comb begin
      acc_in        = acc_ff;
      seen_in       = seen_ff;
      snap_in       = snap_ff;
      snap_valid_in = snap_valid_ff;
      if (snap_move) begin
         snap_valid_in = 1'b0;
      end
      if (item_move) begin
         if (item_ff.last_strip) begin
            snap_in       = acc_upd;
            snap_valid_in = 1'b1;
            acc_in        = HIT_CLEAR;
            seen_in       = '0;
         end else begin
            acc_in = acc_upd;
            if (in_range) begin
               seen_in[item_ff.side][seen_idx] = 1'b1;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: classify the finished hit.
   // ------------------------------------------------------------------
   assign lv_span = snap_ff.lv.max_id - snap_ff.lv.min_id;
   assign hv_span = snap_ff.hv.max_id - snap_ff.hv.min_id;

   always_comb begin
      rsp_data_in                   = rsp_data_ff;
      rsp_valid_in                  = rsp_valid_ff;
      if (snap_move) begin
         rsp_valid_in                  = 1'b1;
         rsp_data_in.grade             = '0;
         rsp_data_in.lv_dominant_id    = snap_ff.lv.id;
         rsp_data_in.hv_dominant_id    = snap_ff.hv.id;
         rsp_data_in.hit_detector      = snap_ff.lv.det;
         rsp_data_in.timing_difference = {1'b0, snap_ff.hv.timing}
                                         - {1'b0, snap_ff.lv.timing};
         if (snap_ff.err[ERR_ZERO_ENERGY]) begin
            rsp_data_in.status = STATUS_ZERO_ENERGY;
         end else if (snap_ff.err[ERR_MULTI_HIT]) begin
            rsp_data_in.status = STATUS_MULTI_HIT;
         end else if (snap_ff.lv.count == '0 || snap_ff.hv.count == '0) begin
            rsp_data_in.status = STATUS_SIDE_EMPTY;
         end else if ({1'b0, hv_span} >= snap_ff.hv.count
                      || {1'b0, lv_span} >= snap_ff.lv.count) begin
            rsp_data_in.status = STATUS_NON_ADJACENT;
         end else begin
            rsp_data_in.grade  = grade_of(snap_ff.lv.count, snap_ff.hv.count);
            if (snap_ff.lv.timing < timing_min_ff || snap_ff.hv.timing < timing_min_ff) begin
               rsp_data_in.status = STATUS_TIMING_MISSING;
            end else begin
               rsp_data_in.status = STATUS_OK;
            end
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         timing_min_ff <= 16'd1;
         item_valid_ff <= 1'b0;
         acc_ff        <= HIT_CLEAR;
         seen_ff       <= '0;
         snap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         timing_min_ff <= timing_min_in;
         item_valid_ff <= item_valid_in;
         acc_ff        <= acc_in;
         seen_ff       <= seen_in;
         snap_valid_ff <= snap_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      snap_ff     <= snap_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      acc_ff.lv.count <= MAX_COUNT && acc_ff.hv.count <= MAX_COUNT)
      else $error("strip count beyond saturation limit");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      item_move && item_ff.last_strip |=>
         acc_ff.lv.count == '0 && acc_ff.hv.count == '0 && acc_ff.err == '0
         && seen_ff == '0 && snap_valid_ff)
      else $error("hit state not cleared or snapshot not taken after last strip");

   a_span_ordered: assert property (@(posedge clock) disable iff (reset)
      (acc_ff.lv.count != '0 |-> acc_ff.lv.min_id <= acc_ff.lv.max_id)
      and (acc_ff.hv.count != '0 |-> acc_ff.hv.min_id <= acc_ff.hv.max_id))
      else $error("lowest strip ID above highest on a populated side");

   a_grade_only_when_graded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status != STATUS_OK
         && rsp_data_ff.status != STATUS_TIMING_MISSING |-> rsp_data_ff.grade == '0)
      else $error("grade set on an error result");

   a_snapshot_not_lost: assert property (@(posedge clock) disable iff (reset)
      snap_valid_ff && !out_free |=> snap_valid_ff && $stable(snap_ff))
      else $error("pending snapshot overwritten or dropped");

endmodule

`default_nettype wire
